FILE: sv/bfs_pkg.sv
// shared types and constants for the binaural fir spatializer
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

  localparam int TAPS_DEF   = 32;
  localparam int HIST_DEF   = 64;
  localparam int XFADE_Q16  = 6554;
  localparam int SMOOTH_Q16 = 3277;
  localparam logic [15:0] GAIN_ONE = 16'd32767;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_XFADE  = 2'd1,
    FUNC_DIST   = 2'd2,
    FUNC_WRITE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HWRITE,
    S_FIR,
    S_DRAIN,
    S_ROUND,
    S_XF_READ,
    S_XF_MUL,
    S_XF_WRITE,
    S_TAP_WRITE,
    S_DIST_MUL,
    S_DIST_UPD,
    S_DIV_START,
    S_DIV_WAIT
  } state_t;

  typedef enum logic [1:0] {
    MSEL_FIR,
    MSEL_SCALE,
    MSEL_XF,
    MSEL_DIST
  } mul_sel_t;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/bfs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/bfs_mac.sv
// shared multiplier pair with accumulators
`timescale 1ns / 1ps
`default_nettype none

module bfs_mac
  import bfs_pkg::*;
#(
  parameter int ACC_W = 37,
  localparam int MUL_W = ACC_W + 18
) (
  input  wire logic                    clk,
  input  wire mac_ctrl_t               ctrl,
  input  wire logic signed [ACC_W-1:0] a_l,
  input  wire logic signed [17:0]      b_l,
  input  wire logic signed [ACC_W-1:0] a_r,
  input  wire logic signed [17:0]      b_r,
  output logic signed      [MUL_W-1:0] prod_l,
  output logic signed      [MUL_W-1:0] prod_r,
  output logic signed      [ACC_W-1:0] acc_l,
  output logic signed      [ACC_W-1:0] acc_r
);

  always_ff @(posedge clk) begin
    prod_l <= a_l * b_l;
    prod_r <= a_r * b_r;
    if (ctrl.acc_clr) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_l <= acc_l + ACC_W'(prod_l);
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

endmodule

`default_nettype wire

FILE: sv/bfs_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bfs_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [17:0] den,
  output logic             done,
  output logic      [31:0] quo
);

  logic        run;
  logic [4:0]  cnt;
  logic [18:0] rem;
  logic [31:0] nsh;
  logic [17:0] dreg;
  logic [18:0] trial;

  assign trial = {rem[17:0], nsh[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      nsh  <= num;
      dreg <= den;
      quo  <= '0;
    end else if (run) begin
      nsh <= {nsh[30:0], 1'b0};
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/binaural_fir_spatializer_core.sv
// top level: sequencer, history and coefficient memories, output register
`timescale 1ns / 1ps
`default_nettype none

// One item at a time; in_stall is high from the transfer until the item is done.
// In a sample item the taps go one per cycle through the history and coefficient
// memory read ports into one shared multiplier pair, then one more product scales
// by the distance gain. A crossfade item reads, multiplies and writes back its tap,
// a direct tap write writes it, an item with a tap index not below TAPS is dropped
// without a stall, and a distance item waits for the 32-step gain divider. Results
// wait in an output register; a sample item finishing while that register is still
// stalled waits for it. History entries not yet written read as zero through a fill
// count, so no clearing pass runs after reset.
module binaural_fir_spatializer_core
  import bfs_pkg::*;
#(
  parameter int TAPS          = TAPS_DEF,
  parameter int HISTORY_DEPTH = HIST_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic signed [15:0] left_in,
  input  wire logic signed [15:0] right_in,
  input  wire logic [4:0]         tap,
  input  wire logic signed [15:0] coef_left,
  input  wire logic signed [15:0] coef_right,
  input  wire logic [15:0]        target_distance,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      left_out,
  output logic signed [15:0]      right_out
);

  localparam int KW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int HW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCW   = $clog2(HISTORY_DEPTH + 1);
  localparam int ACC_W = 32 + $clog2(TAPS);
  localparam int MUL_W = ACC_W + 18;

  localparam logic signed [MUL_W-1:0] HALF30 = MUL_W'(1 << 29);
  localparam logic signed [MUL_W-1:0] HALF16 = MUL_W'(1 << 15);
  localparam logic signed [MUL_W-1:0] SAT_HI = MUL_W'(32767);
  localparam logic signed [MUL_W-1:0] SAT_LO = -MUL_W'(32768);

  state_t state, state_next;

  logic               accept;
  logic signed [15:0] lat_left;
  logic signed [15:0] lat_right;
  logic [KW-1:0]      tap_addr;
  logic signed [15:0] tgt_l;
  logic signed [15:0] tgt_r;
  logic [15:0]        tdist;
  logic [8:0]         tap_ext;
  logic               tap_ok;

  logic [HW-1:0]  wp;
  logic [HCW-1:0] fill;
  logic [HW-1:0]  rd_idx;
  logic [KW-1:0]  k;
  logic           p1;
  logic           p2;
  logic           hv_q;
  logic           cv_q;
  logic [TAPS-1:0] cvalid;

  logic [15:0] sm_dist;
  logic [15:0] gain;
  logic signed [15:0] cur_l;
  logic signed [15:0] cur_r;

  logic        hist_we;
  logic [15:0] hist_wdata;
  logic [15:0] hist_rdata;
  logic        cram_we;
  logic [31:0] cram_wdata;
  logic [KW-1:0] craddr;
  logic [31:0] cram_rdata;
  mul_sel_t    msel;
  mac_ctrl_t   mctl;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;
  logic [17:0] div_den;
  logic [31:0] div_num;
  logic        out_load;

  logic signed [ACC_W-1:0] a_l, a_r;
  logic signed [17:0]      b_l, b_r;
  logic signed [MUL_W-1:0] prod_l, prod_r;
  logic signed [ACC_W-1:0] acc_l, acc_r;

  logic signed [15:0] mono_eff;
  logic signed [15:0] cl_eff;
  logic signed [15:0] cr_eff;
  logic signed [16:0] xd_l;
  logic signed [16:0] xd_r;
  logic signed [16:0] dd;
  logic signed [MUL_W-1:0] ol_sh, or_sh, xl_sh, xr_sh, dr_sh;
  logic signed [15:0] ol_sat, or_sat;
  logic signed [17:0] dn;
  logic [15:0] sm_dist_next;

  assign accept  = in_valid && !in_stall;
  assign tap_ext = 9'(tap);
  assign tap_ok  = tap_ext < 9'(TAPS);

  assign hist_wdata = 16'((17'(lat_left) + 17'(lat_right)) >>> 1);
  assign mono_eff   = hv_q ? $signed(hist_rdata) : '0;
  assign cl_eff     = cv_q ? $signed(cram_rdata[31:16]) : '0;
  assign cr_eff     = cv_q ? $signed(cram_rdata[15:0]) : '0;
  assign xd_l       = 17'(tgt_l) - 17'(cl_eff);
  assign xd_r       = 17'(tgt_r) - 17'(cr_eff);
  assign dd         = $signed({1'b0, tdist}) - $signed({1'b0, sm_dist});

  assign ol_sh = (prod_l + HALF30) >>> 30;
  assign or_sh = (prod_r + HALF30) >>> 30;
  assign xl_sh = (prod_l + HALF16) >>> 16;
  assign xr_sh = (prod_r + HALF16) >>> 16;
  assign dr_sh = (prod_l + HALF16) >>> 16;

  assign ol_sat = (ol_sh > SAT_HI) ? 16'sd32767 :
                  (ol_sh < SAT_LO) ? -16'sd32768 : 16'(ol_sh);
  assign or_sat = (or_sh > SAT_HI) ? 16'sd32767 :
                  (or_sh < SAT_LO) ? -16'sd32768 : 16'(or_sh);

  assign dn           = $signed({2'b00, sm_dist}) + 18'(dr_sh);
  assign sm_dist_next = (dn < 18'sd0) ? 16'd0 :
                        (dn > 18'sd65535) ? 16'hffff : 16'(dn);

  assign div_den = 18'd65536 + {2'b00, sm_dist} + {1'b0, sm_dist, 1'b0};
  assign div_num = 32'h8000_0000 + 32'(div_den >> 1);

  always_comb begin
    unique case (msel)
      MSEL_FIR: begin
        a_l = ACC_W'(mono_eff);
        b_l = 18'(cl_eff);
        a_r = ACC_W'(mono_eff);
        b_r = 18'(cr_eff);
      end
      MSEL_SCALE: begin
        a_l = acc_l;
        b_l = $signed({2'b00, gain});
        a_r = acc_r;
        b_r = $signed({2'b00, gain});
      end
      MSEL_XF: begin
        a_l = ACC_W'(xd_l);
        b_l = 18'(XFADE_Q16);
        a_r = ACC_W'(xd_r);
        b_r = 18'(XFADE_Q16);
      end
      default: begin
        a_l = ACC_W'(dd);
        b_l = 18'(SMOOTH_Q16);
        a_r = '0;
        b_r = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = (state != S_IDLE);
    hist_we      = 1'b0;
    cram_we      = 1'b0;
    cram_wdata   = {tgt_l, tgt_r};
    craddr       = tap_addr;
    msel         = MSEL_FIR;
    mctl.acc_clr = 1'b0;
    mctl.acc_en  = p2;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func_t'(func))
            FUNC_SAMPLE: state_next = S_HWRITE;
            FUNC_XFADE:  state_next = tap_ok ? S_XF_READ : S_IDLE;
            FUNC_DIST:   state_next = S_DIST_MUL;
            FUNC_WRITE:  state_next = tap_ok ? S_TAP_WRITE : S_IDLE;
          endcase
        end
      end
      S_HWRITE: begin
        hist_we      = 1'b1;
        mctl.acc_clr = 1'b1;
        state_next   = S_FIR;
      end
      S_FIR: begin
        craddr = k;
        if (k == KW'(TAPS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1 && !p2) begin
          msel       = MSEL_SCALE;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        msel     = MSEL_SCALE;
        out_load = !out_valid || !out_stall;
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      S_XF_READ: begin
        state_next = S_XF_MUL;
      end
      S_XF_MUL: begin
        msel       = MSEL_XF;
        state_next = S_XF_WRITE;
      end
      S_XF_WRITE: begin
        cram_we    = 1'b1;
        cram_wdata = {16'(cur_l) + 16'(xl_sh), 16'(cur_r) + 16'(xr_sh)};
        state_next = S_IDLE;
      end
      S_TAP_WRITE: begin
        cram_we    = 1'b1;
        state_next = S_IDLE;
      end
      S_DIST_MUL: begin
        msel       = MSEL_DIST;
        state_next = S_DIST_UPD;
      end
      S_DIST_UPD: begin
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lat_left  <= left_in;
      lat_right <= right_in;
      tap_addr  <= tap_ext[KW-1:0];
      tgt_l     <= coef_left;
      tgt_r     <= coef_right;
      tdist     <= target_distance;
    end
    if (state == S_HWRITE) begin
      rd_idx <= wp;
      k      <= '0;
    end
    if (state == S_FIR) begin
      rd_idx <= (rd_idx == '0) ? HW'(HISTORY_DEPTH - 1) : rd_idx - 1'b1;
      k      <= k + 1'b1;
    end
    hv_q <= (HCW'(rd_idx) < fill);
    cv_q <= cvalid[craddr];
    if (state == S_XF_MUL) begin
      cur_l <= cl_eff;
      cur_r <= cr_eff;
    end
    if (out_load) begin
      left_out  <= ol_sat;
      right_out <= or_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      fill      <= '0;
      p1        <= 1'b0;
      p2        <= 1'b0;
      cvalid    <= '0;
      sm_dist   <= '0;
      gain      <= GAIN_ONE;
      out_valid <= 1'b0;
    end else begin
      p1 <= (state == S_FIR);
      p2 <= p1;
      if (state == S_HWRITE) begin
        wp <= (wp == HW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
        if (fill != HCW'(HISTORY_DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end
      if (cram_we) begin
        cvalid[tap_addr] <= 1'b1;
      end
      if (state == S_DIST_UPD) begin
        sm_dist <= sm_dist_next;
      end
      if (state == S_DIV_WAIT && div_done) begin
        gain <= (div_quo > 32'd32767) ? GAIN_ONE : div_quo[15:0];
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  bfs_ram #(
    .WIDTH(16),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(wp),
    .wdata(hist_wdata),
    .raddr(rd_idx),
    .rdata(hist_rdata)
  );

  bfs_ram #(
    .WIDTH(32),
    .DEPTH(TAPS)
  ) u_coef (
    .clk  (clk),
    .we   (cram_we),
    .waddr(tap_addr),
    .wdata(cram_wdata),
    .raddr(craddr),
    .rdata(cram_rdata)
  );

  bfs_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk   (clk),
    .ctrl  (mctl),
    .a_l   (a_l),
    .b_l   (b_l),
    .a_r   (a_r),
    .b_r   (b_r),
    .prod_l(prod_l),
    .prod_r(prod_r),
    .acc_l (acc_l),
    .acc_r (acc_r)
  );

  bfs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

endmodule

`default_nettype wire

FILE: sv/bfs_checker.sv
// port level checker for the spatializer core and its bind
`timescale 1ns / 1ps
`default_nettype none

module bfs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] left_out,
  input wire logic [15:0] right_out
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled result changed");

  // block is busy right after a transfer in
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took no time for an item");

  // a new result appears only as the busy period ends
  a_result_ends_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall) && !in_stall)
    else $error("result outside the end of an item");

  // reset leaves the block idle and empty
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind binaural_fir_spatializer_core bfs_checker u_bfs_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .left_out (left_out),
  .right_out(right_out)
);

`default_nettype wire

FILE: tb/sv/bfs_checker.sv
// checker for the binaural fir spatializer: predicts ear outputs and compares
`timescale 1ns / 1ps

module bfs_scoreboard
  import bfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  input  logic [4:0]         tap,
  input  logic signed [15:0] coef_left,
  input  logic signed [15:0] coef_right,
  input  logic [15:0]        target_distance,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] left_out,
  input  logic signed [15:0] right_out,
  output int                 mismatches,
  output int                 awaiting,
  output int                 compared
);

  localparam int NTAPS  = TAPS_DEF;
  localparam int HDEPTH = HIST_DEF;

  typedef struct packed {
    logic signed [15:0] left_s;
    logic signed [15:0] right_s;
  } ear_pair_t;

  ear_pair_t expected_ears[$];

  int hist[HDEPTH];
  int lcoef[NTAPS];
  int rcoef[NTAPS];
  int wpos;
  int sdist;
  int gain;
  int err_n;
  int cmp_n;

  function automatic int glide_q16(int cur, int target, int rate);
    longint delta;
    delta = longint'(target) - longint'(cur);
    return cur + int'((delta * rate + 64'sd32768) >>> 16);
  endfunction

  function automatic int gain_for_distance(int d);
    longint den;
    longint g;
    den = 64'sd65536 + 3 * longint'(d);
    g = ((longint'(1) << 31) + den / 2) / den;
    return (g > 32767) ? 32767 : int'(g);
  endfunction

  function automatic logic signed [15:0] scale_ear(longint acc, int g);
    longint v;
    v = (acc * g + (longint'(1) << 29)) >>> 30;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  initial begin
    mismatches = 0;
    awaiting   = 0;
    compared   = 0;
  end

  always @(posedge clk) begin : watch
    ear_pair_t want;
    ear_pair_t pred;
    int mono;
    int idx;
    int d;
    longint accl;
    longint accr;
    if (rst) begin
      for (int i = 0; i < HDEPTH; i++) hist[i] = 0;
      for (int i = 0; i < NTAPS; i++) begin
        lcoef[i] = 0;
        rcoef[i] = 0;
      end
      wpos  = 0;
      sdist = 0;
      gain  = int'(GAIN_ONE);
      expected_ears.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_ears.size() == 0) begin
          err_n++;
          $display("%0t: unexpected result transfer, left %0d right %0d", $time,
                   left_out, right_out);
        end else begin
          want = expected_ears.pop_front();
          cmp_n++;
          if (left_out !== want.left_s) begin
            err_n++;
            $display("%0t: left_out expected %0d actual %0d", $time, want.left_s, left_out);
          end
          if (right_out !== want.right_s) begin
            err_n++;
            $display("%0t: right_out expected %0d actual %0d", $time, want.right_s,
                     right_out);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (func_t'(func))
          FUNC_SAMPLE: begin
            mono = (int'(left_in) + int'(right_in)) >>> 1;
            hist[wpos] = mono;
            accl = 0;
            accr = 0;
            for (int k = 0; k < NTAPS; k++) begin
              idx = (wpos + HDEPTH - (k % HDEPTH)) % HDEPTH;
              accl += longint'(hist[idx]) * longint'(lcoef[k]);
              accr += longint'(hist[idx]) * longint'(rcoef[k]);
            end
            pred.left_s  = scale_ear(accl, gain);
            pred.right_s = scale_ear(accr, gain);
            expected_ears.insert(expected_ears.size(), pred);
            wpos = (wpos + 1) % HDEPTH;
          end
          FUNC_XFADE: begin
            if (tap < NTAPS) begin
              lcoef[tap] = glide_q16(lcoef[tap], int'(coef_left), XFADE_Q16);
              rcoef[tap] = glide_q16(rcoef[tap], int'(coef_right), XFADE_Q16);
            end
          end
          FUNC_DIST: begin
            d = glide_q16(sdist, int'(target_distance), SMOOTH_Q16);
            if (d < 0) d = 0;
            if (d > 65535) d = 65535;
            sdist = d;
            gain  = gain_for_distance(sdist);
          end
          FUNC_WRITE: begin
            if (tap < NTAPS) begin
              lcoef[tap] = int'(coef_left);
              rcoef[tap] = int'(coef_right);
            end
          end
          default: ;
        endcase
      end
    end
    mismatches <= err_n;
    awaiting   <= expected_ears.size();
    compared   <= cmp_n;
  end

endmodule

FILE: tb/sv/tb.sv
// testbench top for the binaural fir spatializer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import bfs_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int SQUEEZE_HOLD = 400;
  localparam int RANDOM_ITEMS = 1000;
  localparam int SETTLE       = 40;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         func;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;
  logic [4:0]         tap;
  logic signed [15:0] coef_left;
  logic signed [15:0] coef_right;
  logic [15:0]        target_distance;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  int  mismatches;
  int  awaiting;
  int  compared;
  int  idle_cycles;
  int  func_count[4];
  logic no_idle;
  logic squeeze_req;

  binaural_fir_spatializer_core DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .left_in         (left_in),
    .right_in        (right_in),
    .tap             (tap),
    .coef_left       (coef_left),
    .coef_right      (coef_right),
    .target_distance (target_distance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .left_out        (left_out),
    .right_out       (right_out)
  );

  bfs_scoreboard u_scoreboard (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .left_in         (left_in),
    .right_in        (right_in),
    .tap             (tap),
    .coef_left       (coef_left),
    .coef_right      (coef_right),
    .target_distance (target_distance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .left_out        (left_out),
    .right_out       (right_out),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .compared        (compared)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 16'sh7fff;
    if (r < 6) return 16'sh8000;
    if (r < 8) return 16'sh0000;
    if (r < 10) return 16'shffff;
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'sh7fff;
    if (r < 15) return 16'sh8000;
    if (r < 60) return 16'($signed($urandom_range(0, 4095)) - 2048);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_distance();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 16'hffff;
    if (r < 22) return 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send_item(input func_t f, input logic signed [15:0] l, r,
                           input logic [4:0] t, input logic signed [15:0] cl, cr,
                           input logic [15:0] td);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    func            <= f;
    left_in         <= l;
    right_in        <= r;
    tap             <= t;
    coef_left       <= cl;
    coef_right      <= cr;
    target_distance <= td;
    do @(posedge clk); while (in_stall);
    func_count[f]++;
  endtask

  task automatic send_random();
    int r;
    func_t f;
    r = $urandom_range(0, 99);
    if (r < 55) f = FUNC_SAMPLE;
    else if (r < 70) f = FUNC_XFADE;
    else if (r < 85) f = FUNC_WRITE;
    else f = FUNC_DIST;
    send_item(f, pick_sample(), pick_sample(), 5'($urandom), pick_coef(), pick_coef(),
              pick_distance());
  endtask

  // receiver: random stall, one long hold when asked
  initial begin : receiver
    logic squeezed;
    logic v;
    int   d;
    int   r;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        v = 1'b1;
        d = SQUEEZE_HOLD;
      end else if (no_idle) begin
        v = 1'b0;
        d = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          v = 1'b0;
          d = $urandom_range(1, 8);
        end else if (r < 90) begin
          v = 1'b1;
          d = $urandom_range(1, 3);
        end else if (r < 98) begin
          v = 1'b1;
          d = $urandom_range(4, 20);
        end else begin
          v = 1'b1;
          d = $urandom_range(40, 100);
        end
      end
      out_stall <= v;
      repeat (d) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("binaural_fir_spatializer_core verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < 4; i++) func_count[i] = 0;
    idle_cycles     = 0;
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    func            <= FUNC_SAMPLE;
    left_in         <= '0;
    right_in        <= '0;
    tap             <= '0;
    coef_left       <= '0;
    coef_right      <= '0;
    target_distance <= '0;
    no_idle         <= 1'b0;
    squeeze_req     <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_item(FUNC_SAMPLE, 16'sd0, 16'sd0, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_WRITE, 16'sd0, 16'sd0, 5'd0, 16'sh7fff, 16'sh8000, 16'd0);
    send_item(FUNC_WRITE, 16'sd0, 16'sd0, 5'd31, 16'sh8000, 16'sh7fff, 16'd0);
    send_item(FUNC_SAMPLE, 16'sh7fff, 16'sh7fff, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_SAMPLE, 16'sh8000, 16'sh8000, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_SAMPLE, -16'sd1, 16'sd0, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_SAMPLE, 16'sh7fff, 16'sh8000, 5'd0, 16'sd0, 16'sd0, 16'd0);
    for (int t = 1; t < 4; t++)
      send_item(FUNC_WRITE, 16'sd0, 16'sd0, 5'(t), 16'sh7fff, 16'sh8000, 16'd0);
    send_item(FUNC_SAMPLE, 16'sh7fff, 16'sh7fff, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_SAMPLE, 16'sh7fff, 16'sh7fff, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_XFADE, 16'sd0, 16'sd0, 5'd5, 16'sh7fff, 16'sh8000, 16'd0);
    send_item(FUNC_XFADE, 16'sd0, 16'sd0, 5'd5, 16'sh7fff, 16'sh8000, 16'd0);
    send_item(FUNC_XFADE, 16'sd0, 16'sd0, 5'd0, 16'sh7fff, 16'sh8000, 16'd0);
    send_item(FUNC_XFADE, 16'sd0, 16'sd0, 5'd4, 16'sh8000, 16'sh7fff, 16'd0);
    send_item(FUNC_SAMPLE, 16'sh8000, 16'sh7fff, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_DIST, 16'sd0, 16'sd0, 5'd0, 16'sd0, 16'sd0, 16'hffff);
    send_item(FUNC_DIST, 16'sd0, 16'sd0, 5'd0, 16'sd0, 16'sd0, 16'hffff);
    send_item(FUNC_SAMPLE, 16'sd20000, 16'sd20000, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_DIST, 16'sd0, 16'sd0, 5'd0, 16'sd0, 16'sd0, 16'h0000);
    send_item(FUNC_SAMPLE, 16'sh7fff, 16'sh7fff, 5'd0, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_WRITE, 16'sd0, 16'sd0, 5'd7, 16'sd0, 16'sd0, 16'd0);
    send_item(FUNC_SAMPLE, 16'sh8000, 16'sh8000, 5'd0, 16'sd0, 16'sd0, 16'd0);

    // random part in blocks, some with no idling, one with a long receiver hold
    for (int b = 0; b < RANDOM_ITEMS / 100; b++) begin
      if (b == 3) begin
        no_idle     <= 1'b0;
        squeeze_req <= 1'b1;
        for (int i = 0; i < 12; i++)
          send_item(FUNC_SAMPLE, pick_sample(), pick_sample(), 5'd0, 16'sd0, 16'sd0,
                    16'd0);
      end else begin
        no_idle <= ($urandom_range(0, 4) == 0);
      end
      for (int i = 0; i < 100; i++) send_random();
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE) @(posedge clk);

    $display("items: %0d sample, %0d crossfade, %0d distance, %0d tap write",
             func_count[FUNC_SAMPLE], func_count[FUNC_XFADE], func_count[FUNC_DIST],
             func_count[FUNC_WRITE]);
    $display("ear output pairs compared: %0d, mismatches: %0d", compared, mismatches);
    if (mismatches == 0 && awaiting == 0) begin
      $display("binaural_fir_spatializer_core verification clean");
    end else begin
      $display("binaural_fir_spatializer_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bfs_pkg.sv
sv/bfs_ram.sv
sv/bfs_mac.sv
sv/bfs_div.sv
sv/binaural_fir_spatializer_core.sv
sv/bfs_checker.sv
tb/sv/bfs_checker.sv
tb/sv/tb.sv
